### hw/rtl/path_arc_length_index_unit_macros.svh
// Assertion macros for the path arc-length index unit.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef PATH_ARC_LENGTH_INDEX_UNIT_MACROS_SVH
`define PATH_ARC_LENGTH_INDEX_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PALI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
// Next-cycle implication checked outside reset.
`define PALI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### hw/rtl/pali_pkg.sv
// Shared types and constants for the path arc-length index unit.
// No dependencies.
`timescale 1ns / 1ps
package pali_pkg;
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [2:0] ST_APPENDED = 3'd0;
   localparam logic [2:0] ST_FOUND    = 3'd1;
   localparam logic [2:0] ST_BEYOND   = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   localparam logic [16:0] TWO_PI_Q13 = 17'd51472;
   localparam logic [39:0] LEN_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [15:0] WEIGHT_RESET = 16'd256;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] heading;
      logic [39:0] query_length;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [39:0] path_length;
      logic [9:0]  pose_index;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] heading;
   } rsp_type;
endpackage

### hw/rtl/pali_cmd_queue.sv
// Two-entry command queue between the front end and the execution engine.
// Depends on pali_pkg.
`timescale 1ns / 1ps
module pali_cmd_queue
   import pali_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end
endmodule

### hw/rtl/pali_engine.sv
// Execution engine: pose memories, step-length square root, linear length search.
// Depends on pali_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "path_arc_length_index_unit_macros.svh"
module pali_engine
   import pali_pkg::*;
#(
   parameter int MAX_POSES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] weight,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp
);
   localparam int AW = (MAX_POSES > 2) ? $clog2(MAX_POSES) : 1;
   localparam int CW = $clog2(MAX_POSES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RDPREV, S_WAITPREV, S_DIFF, S_SQ, S_SUM, S_ROOT, S_LEN, S_WRITE,
      S_SRCH, S_SRCHCMP, S_RDOUT, S_WAITOUT, S_EMIT, S_HOLD
   } state_type;

   logic [31:0] x_mem [MAX_POSES];
   logic [31:0] y_mem [MAX_POSES];
   logic [31:0] z_mem [MAX_POSES];
   logic [47:0] a_mem [MAX_POSES];
   logic [39:0] l_mem [MAX_POSES];

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] addr_ff;
   logic [31:0] rx_ff, ry_ff, rz_ff;
   logic [47:0] ra_ff;
   logic [39:0] rl_ff;
   logic [32:0] dx_ff, dy_ff, dz_ff;
   logic [16:0] dh_ff;
   logic [65:0] sx_ff, sy_ff, sz_ff;
   logic [33:0] hsq_ff;
   logic [67:0] rad_ff;
   logic [35:0] rem_ff;
   logic [35:0] root_ff;
   logic [5:0]  bit_ff;
   logic [39:0] len_ff;
   logic [2:0]  st_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   logic        wr_en;

   // Wrapped heading difference, min(|d|, |d+2pi|, |d-2pi|, 2pi).
   logic signed [17:0] dh_raw;
   logic [17:0] h0, h1, h2, hmin;
   always_comb begin
      dh_raw = $signed({{2{cmd_ff.heading[15]}}, cmd_ff.heading})
             - $signed({{2{ra_ff[47]}}, ra_ff[47:32]});
      h0 = dh_raw[17] ? -dh_raw : dh_raw;
      h1 = (dh_raw + 18'(TWO_PI_Q13));
      h1 = h1[17] ? -h1 : h1;
      h2 = (dh_raw - 18'(TWO_PI_Q13));
      h2 = h2[17] ? -h2 : h2;
      hmin = 18'(TWO_PI_Q13);
      if (h0 < hmin) hmin = h0;
      if (h1 < hmin) hmin = h1;
      if (h2 < hmin) hmin = h2;
   end

   function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({a[31], a}) - $signed({b[31], b});
      return d[32] ? 33'(-d) : 33'(d);
   endfunction

   // Restoring square root, one result bit per cycle (two radicand bits).
   logic [37:0] trial;
   logic [37:0] rem_sh;
   assign rem_sh = {rem_ff, rad_ff[67:66]};
   assign trial  = {root_ff, 2'b01};

   logic [40:0] len_sum;
   assign len_sum = {1'b0, rl_ff} + {5'd0, root_ff};

   assign cmd_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign wr_en     = (state_ff == S_WRITE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[addr_ff] <= cmd_ff.pos_x;
         y_mem[addr_ff] <= cmd_ff.pos_y;
         z_mem[addr_ff] <= cmd_ff.pos_z;
         a_mem[addr_ff] <= {cmd_ff.heading, cmd_ff.pitch, cmd_ff.roll};
         l_mem[addr_ff] <= len_ff;
      end
      rx_ff <= x_mem[addr_ff];
      ry_ff <= y_mem[addr_ff];
      rz_ff <= z_mem[addr_ff];
      ra_ff <= a_mem[addr_ff];
      rl_ff <= l_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cmd_ff <= cmd;
                  case (cmd.opcode)
                     OP_APPEND: begin
                        if (CW'(MAX_POSES) <= count_ff) begin
                           rsp_ff   <= '{status: ST_FULL, default: '0};
                           state_ff <= S_HOLD;
                        end else if (count_ff == '0) begin
                           len_ff   <= '0;
                           addr_ff  <= '0;
                           state_ff <= S_WRITE;
                        end else begin
                           addr_ff  <= AW'(count_ff - 1'b1);
                           state_ff <= S_RDPREV;
                        end
                     end
                     OP_QUERY: begin
                        if (count_ff == '0) begin
                           rsp_ff   <= '{status: ST_EMPTY, default: '0};
                           state_ff <= S_HOLD;
                        end else begin
                           addr_ff  <= '0;
                           state_ff <= S_SRCH;
                        end
                     end
                     OP_CLEAR: begin
                        count_ff <= '0;
                        rsp_ff   <= '{status: ST_CLEARED, default: '0};
                        state_ff <= S_HOLD;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_RDPREV:   state_ff <= S_WAITPREV;
            S_WAITPREV: state_ff <= S_DIFF;
            S_DIFF: begin
               dx_ff <= absd(rx_ff, cmd_ff.pos_x);
               dy_ff <= absd(ry_ff, cmd_ff.pos_y);
               dz_ff <= absd(rz_ff, cmd_ff.pos_z);
               dh_ff <= hmin[16:0];
               state_ff <= S_SQ;
            end
            S_SQ: begin
               sx_ff  <= dx_ff * dx_ff;
               sy_ff  <= dy_ff * dy_ff;
               sz_ff  <= dz_ff * dz_ff;
               hsq_ff <= dh_ff * dh_ff;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // heading term: weight * dyaw^2 >> 2
               rad_ff  <= 68'(sx_ff) + 68'(sy_ff) + 68'(sz_ff)
                        + 68'((50'(weight) * 50'(hsq_ff)) >> 2);
               rem_ff  <= '0;
               root_ff <= '0;
               bit_ff  <= 6'd33;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               // bring down the next two radicand bits and try 4*root+1
               if (rem_sh >= trial) begin
                  rem_ff  <= 36'(rem_sh - trial);
                  root_ff <= {root_ff[34:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh[35:0];
                  root_ff <= {root_ff[34:0], 1'b0};
               end
               rad_ff <= {rad_ff[65:0], 2'b00};
               if (bit_ff == '0) state_ff <= S_LEN;
               else bit_ff <= bit_ff - 1'b1;
            end
            S_LEN: begin
               // rl_ff still holds the previous pose's length
               len_ff   <= len_sum[40] ? LEN_MAX : len_sum[39:0];
               addr_ff  <= AW'(count_ff);
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               state_ff <= S_RDOUT;
               count_ff <= count_ff + 1'b1;
               st_ff    <= ST_APPENDED;
            end
            S_SRCH:    state_ff <= S_SRCHCMP;
            S_SRCHCMP: begin
               if (rl_ff >= cmd_ff.query_length) begin
                  st_ff <= ST_FOUND; state_ff <= S_RDOUT;
               end else if (CW'(addr_ff) + 1'b1 >= count_ff) begin
                  st_ff <= ST_BEYOND; state_ff <= S_RDOUT;
               end else begin
                  addr_ff <= addr_ff + 1'b1; state_ff <= S_SRCH;
               end
            end
            S_RDOUT:   state_ff <= S_WAITOUT;
            S_WAITOUT: state_ff <= S_EMIT;
            S_EMIT: begin
               rsp_ff.status      <= st_ff;
               rsp_ff.path_length <= rl_ff;
               rsp_ff.pose_index  <= 10'(addr_ff);
               rsp_ff.x           <= rx_ff;
               rsp_ff.y           <= ry_ff;
               rsp_ff.z           <= rz_ff;
               rsp_ff.roll        <= ra_ff[15:0];
               rsp_ff.pitch       <= ra_ff[31:16];
               rsp_ff.heading     <= ra_ff[47:32];
               state_ff <= S_HOLD;
            end
            S_HOLD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `PALI_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_POSES))
   `PALI_ASSERT_NEXT(a_write_grows, clock, reset, wr_en, count_ff != '0)
   `PALI_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_valid_ff, !cmd_ready)
endmodule

### hw/rtl/pali_front.sv
// Front end: accepts input transfers, drops opcode 3, pushes commands to the queue.
// Depends on pali_pkg.
`timescale 1ns / 1ps
module pali_front
   import pali_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    q_valid,
   input  logic    q_ready,
   output cmd_type q_cmd
);
   cmd_type cmd_ff;
   logic    valid_ff;

   assign in_ready = !valid_ff || q_ready;
   assign q_valid  = valid_ff;
   assign q_cmd    = cmd_ff;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) cmd_ff <= in_cmd;
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid && (in_cmd.opcode != OP_NONE);
      end
   end
endmodule

### hw/rtl/path_arc_length_index_unit.sv
// Top level of the path arc-length index unit.
// Depends on pali_pkg, pali_front, pali_cmd_queue and pali_engine.
`timescale 1ns / 1ps
// Usage:
//  req_ carries commands: append a pose, query by path length, clear the path.
//  rsp_ returns one result per append, query or clear; opcode 3 gives none.
//  csr_ writes heading_weight (unsigned Q8.8); the user writes it only
//  while the block is idle, which the block itself does not enforce.
//  An append runs a 34-step square root, a query a linear length search
//  over the stored poses (one read port on the length memory); clear,
//  empty query and full append answer without either.
//  One item is executed at a time: the engine takes no new command until
//  the last result is taken, but the front register and a two-entry queue
//  take further transfers while the engine works or a result waits.
//  Reset empties the path and sets heading_weight to 1.0; memories keep
//  their contents but are never read past the pose count.
//  A stalled rsp_tready holds the result and stops the engine taking more.
module path_arc_length_index_unit
   import pali_pkg::*;
#(
   parameter int MAX_POSES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, roll_in, pitch_in, heading_in, query_length
   input  logic [183:0] req_tdata,
   // opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // path_length, pose_index, out_x, out_y, out_z, out_roll, out_pitch,
   // out_heading, zero pad
   output logic [199:0] rsp_tdata,
   // status
   output logic [2:0]   rsp_tuser
);
   logic [15:0] weight_ff;
   cmd_type in_cmd, fq_cmd, qe_cmd;
   logic fq_valid, fq_ready, qe_valid, qe_ready;
   rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) weight_ff <= WEIGHT_RESET;
      else if (csr_wen) weight_ff <= csr_wdata;
   end

   assign in_cmd = '{opcode: req_tuser, pos_x: req_tdata[31:0],
      pos_y: req_tdata[63:32], pos_z: req_tdata[95:64], roll: req_tdata[111:96],
      pitch: req_tdata[127:112], heading: req_tdata[143:128],
      query_length: req_tdata[183:144]};

   pali_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd, .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd));

   pali_cmd_queue u_queue (.clock, .reset, .push_valid(fq_valid), .push_ready(fq_ready),
      .push_data(fq_cmd), .pop_valid(qe_valid), .pop_ready(qe_ready), .pop_data(qe_cmd));

   pali_engine #(.MAX_POSES(MAX_POSES)) u_engine (.clock, .reset, .weight(weight_ff),
      .cmd_valid(qe_valid), .cmd_ready(qe_ready), .cmd(qe_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp);

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {6'b000000, rsp.heading, rsp.pitch, rsp.roll, rsp.z, rsp.y, rsp.x,
      rsp.pose_index, rsp.path_length};
endmodule

### tb/sv/path_arc_length_index_unit_tb.sv
// Self-checking testbench for the path arc-length index unit.
// Depends on pali_pkg and path_arc_length_index_unit. A scoreboard class
// predicts each result; plain tasks drive req_ and csr_, an always block rsp_tready.
`timescale 1ns / 1ps

// Scoreboard: a copy of the stored path and of heading_weight, plus a queue of
// predicted results in arrival order.
class path_index_board;
   logic [15:0] weight;
   int          count;
   logic [31:0] xs[1024];
   logic [31:0] ys[1024];
   logic [31:0] zs[1024];
   logic [47:0] angles[1024];
   logic [39:0] lens[1024];
   pali_pkg::rsp_type pending[$];
   int          errors;

   function new();
      weight = pali_pkg::WEIGHT_RESET;
      count  = 0;
      errors = 0;
   endfunction

   static function longint abs_of(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // floor(sqrt(dx^2 + dy^2 + dz^2 + (alpha * dyaw^2 >> 2))) for the step from pose k
   function logic [63:0] arc_step(int k, pali_pkg::cmd_type c);
      longint       d;
      longint       w;
      longint       two_pi;
      logic [127:0] acc;
      logic [127:0] root;
      logic [127:0] trial;
      acc = '0;
      d = abs_of(longint'($signed(c.pos_x)) - longint'($signed(xs[k])));
      acc += 128'(d) * 128'(d);
      d = abs_of(longint'($signed(c.pos_y)) - longint'($signed(ys[k])));
      acc += 128'(d) * 128'(d);
      d = abs_of(longint'($signed(c.pos_z)) - longint'($signed(zs[k])));
      acc += 128'(d) * 128'(d);
      two_pi = longint'(pali_pkg::TWO_PI_Q13);
      d = longint'($signed(c.heading)) - longint'($signed(angles[k][47:32]));
      w = two_pi;
      if (abs_of(d) < w) w = abs_of(d);
      if (abs_of(d + two_pi) < w) w = abs_of(d + two_pi);
      if (abs_of(d - two_pi) < w) w = abs_of(d - two_pi);
      acc += (128'(weight) * 128'(w) * 128'(w)) >> 2;
      // bit-serial integer square root, result below 2^35
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         trial = root | (128'(1) << b);
         if (trial * trial <= acc) root = trial;
      end
      return root[63:0];
   endfunction

   function pali_pkg::rsp_type pose_result(int k, logic [2:0] status);
      pali_pkg::rsp_type r;
      r.status      = status;
      r.path_length = lens[k];
      r.pose_index  = k[9:0];
      r.x           = xs[k];
      r.y           = ys[k];
      r.z           = zs[k];
      r.roll        = angles[k][15:0];
      r.pitch       = angles[k][31:16];
      r.heading     = angles[k][47:32];
      return r;
   endfunction

   // Note an accepted command: update the path copy and queue its result.
   function void note_command(pali_pkg::cmd_type c);
      pali_pkg::rsp_type r;
      logic [63:0] len;
      int k;
      r = '0;
      case (c.opcode)
         pali_pkg::OP_APPEND: begin
            if (count >= 1024) begin
               r.status = pali_pkg::ST_FULL;
            end else begin
               len = '0;
               if (count > 0) begin
                  len = 64'(lens[count-1]) + arc_step(count - 1, c);
                  if (len > 64'(pali_pkg::LEN_MAX)) len = 64'(pali_pkg::LEN_MAX);
               end
               xs[count]     = c.pos_x;
               ys[count]     = c.pos_y;
               zs[count]     = c.pos_z;
               angles[count] = {c.heading, c.pitch, c.roll};
               lens[count]   = len[39:0];
               r = pose_result(count, pali_pkg::ST_APPENDED);
               count++;
            end
         end
         pali_pkg::OP_QUERY: begin
            if (count == 0) begin
               r.status = pali_pkg::ST_EMPTY;
            end else begin
               k = 0;
               while (k < count && lens[k] < c.query_length) k++;
               if (k < count) r = pose_result(k, pali_pkg::ST_FOUND);
               else r = pose_result(count - 1, pali_pkg::ST_BEYOND);
            end
         end
         pali_pkg::OP_CLEAR: begin
            count = 0;
            r.status = pali_pkg::ST_CLEARED;
         end
         default: return;  // no-op opcode gives no result
      endcase
      pending = {pending, r};
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   // Check a result transfer against the oldest prediction.
   function void check_result(pali_pkg::rsp_type got);
      pali_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $error("unexpected result, status %0d", got.status);
         errors++;
         return;
      end
      want = pending.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("path_length", want.path_length, got.path_length);
      compare_field("pose_index", want.pose_index, got.pose_index);
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
      compare_field("out_roll", want.roll, got.roll);
      compare_field("out_pitch", want.pitch, got.pitch);
      compare_field("out_heading", want.heading, got.heading);
   endfunction
endclass

module path_arc_length_index_unit_tb;
   import pali_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [15:0] HEADING_MAX = 16'sd25736;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wen = 1'b0;
   logic [15:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [183:0] req_tdata = '0;
   logic [1:0]   req_tuser = OP_NONE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   path_index_board board = new();

   // 0: sender idles 8%, receiver 46%; 1: the other way round; 2: no idling
   int  idle_mode = 0;
   int  hold_asked = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   longint cycle_count = 0;

   // Last appended pose, used as the base of random walks.
   logic [31:0] walk_x, walk_y, walk_z;

   path_arc_length_index_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Abort on hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("path_arc_length_index_unit_tb failed");
         $finish;
      end
   end

   // Receiver: random stalls per idle mode; a requested hold-off drops tready
   // for a long stretch so the block fills up and stalls its input.
   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (idle_mode)
            0: rsp_tready <= ($urandom_range(0, 99) >= 46);
            1: rsp_tready <= ($urandom_range(0, 99) >= 8);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // Unpack and check every result transfer.
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tuser;
         got.path_length = rsp_tdata[39:0];
         got.pose_index  = rsp_tdata[49:40];
         got.x           = rsp_tdata[81:50];
         got.y           = rsp_tdata[113:82];
         got.z           = rsp_tdata[145:114];
         got.roll        = rsp_tdata[161:146];
         got.pitch       = rsp_tdata[177:162];
         got.heading     = rsp_tdata[193:178];
         board.check_result(got);
      end
   end

   // Offer one command after a random gap; hold it until the transfer.
   task automatic send_cmd(cmd_type c);
      int gap;
      gap = 0;
      if (idle_mode == 0) while ($urandom_range(0, 99) < 8) gap++;
      if (idle_mode == 1) while ($urandom_range(0, 99) < 46) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.opcode;
      req_tdata  <= {c.query_length, c.heading, c.pitch, c.roll,
                     c.pos_z, c.pos_y, c.pos_x};
      do @(posedge clock); while (!req_tready);
      board.note_command(c);
      if (c.opcode == OP_APPEND) begin
         walk_x = c.pos_x;
         walk_y = c.pos_y;
         walk_z = c.pos_z;
      end
   endtask

   // Stop offering and wait until every predicted result has arrived.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_weight(logic [15:0] value);
      drain_results();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      board.weight = value;
   endtask

   function automatic logic [39:0] any_length();
      return {8'($urandom_range(0, 255)), 32'($urandom)};
   endfunction

   function automatic cmd_type pose_cmd(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [15:0] heading);
      cmd_type c;
      c.opcode       = OP_APPEND;
      c.pos_x        = x;
      c.pos_y        = y;
      c.pos_z        = z;
      c.roll         = 16'($urandom);
      c.pitch        = 16'($urandom);
      c.heading      = heading;
      c.query_length = any_length();
      return c;
   endfunction

   function automatic cmd_type query_cmd(logic [39:0] q);
      cmd_type c;
      c = pose_cmd($urandom, $urandom, $urandom, 16'($urandom));
      c.opcode       = OP_QUERY;
      c.query_length = q;
      return c;
   endfunction

   function automatic cmd_type plain_cmd(logic [1:0] op);
      cmd_type c;
      c = pose_cmd($urandom, $urandom, $urandom, 16'($urandom));
      c.opcode = op;
      return c;
   endfunction

   function automatic logic [31:0] walk_step(logic [31:0] base);
      int sh;
      sh = $urandom_range(0, 22);
      return base + ($urandom & ((32'd2 << sh) - 1)) - (32'd1 << sh);
   endfunction

   function automatic logic [15:0] any_heading();
      return 16'($urandom_range(0, 51472)) - HEADING_MAX;
   endfunction

   // Query length aimed at the stored lengths: exact hits, neighbors, ends.
   function automatic logic [39:0] aimed_length();
      int k;
      logic [39:0] l;
      if (board.count == 0) return any_length();
      k = $urandom_range(0, board.count - 1);
      l = board.lens[k];
      case ($urandom_range(0, 6))
         0, 1: return l;
         2: return (l == 0) ? l : l - 40'd1;
         3: return l + 40'd1;
         4: return '0;
         5: return board.lens[board.count-1] + 40'd1 + 40'($urandom_range(0, 1000));
         default: return any_length();
      endcase
   endfunction

   // Random part: mostly well-formed walks with aimed queries, some noise.
   task automatic random_items(int total);
      int sent;
      int run;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 9))
            0: begin
               send_cmd(plain_cmd(OP_CLEAR));
               sent++;
            end
            1: begin
               // noise: raw poses, raw queries, no-op
               case ($urandom_range(0, 2))
                  0: send_cmd(pose_cmd($urandom, $urandom, $urandom, 16'($urandom)));
                  1: send_cmd(query_cmd(any_length()));
                  default: send_cmd(plain_cmd(OP_NONE));
               endcase
               sent++;
            end
            2, 3, 4, 5: begin
               run = $urandom_range(1, 12);
               repeat (run) begin
                  if (board.count >= 1000) send_cmd(plain_cmd(OP_CLEAR));
                  else send_cmd(pose_cmd(walk_step(walk_x), walk_step(walk_y),
                                         walk_step(walk_z), any_heading()));
               end
               sent += run;
            end
            default: begin
               send_cmd(query_cmd(aimed_length()));
               sent++;
            end
         endcase
      end
   endtask

   initial begin
      walk_x = '0;
      walk_y = '0;
      walk_z = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty query, extremes of position and heading, heading wrap, beyond end.
      send_cmd(query_cmd('0));
      send_cmd(pose_cmd('0, '0, '0, '0));
      send_cmd(pose_cmd(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, HEADING_MAX));
      send_cmd(pose_cmd(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -HEADING_MAX));
      send_cmd(pose_cmd(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, HEADING_MAX));
      send_cmd(pose_cmd(32'h0001_0000, '0, '0, 16'h8000));
      send_cmd(pose_cmd(32'h0001_0000, '0, '0, 16'h7FFF));
      send_cmd(pose_cmd(32'h0001_0000, '0, '0, 16'h7FFF));
      send_cmd(plain_cmd(OP_NONE));
      send_cmd(query_cmd('0));
      send_cmd(query_cmd(board.lens[2]));
      send_cmd(query_cmd(board.lens[3] - 40'd1));
      send_cmd(query_cmd(board.lens[6] + 40'd1));
      send_cmd(query_cmd(LEN_MAX));
      send_cmd(plain_cmd(OP_CLEAR));
      send_cmd(query_cmd(40'd5));
      send_cmd(pose_cmd('1, '1, '1, '0));
      send_cmd(query_cmd('0));

      write_weight(16'd0);
      random_items(100);
      write_weight(16'hFFFF);
      random_items(100);

      // Phase two: sender idles more than the receiver; long receiver hold-off.
      idle_mode = 1;
      write_weight(16'($urandom));
      hold_asked++;
      random_items(120);
      write_weight(16'd1);
      random_items(80);

      // Phase three: no idling. Drive the cumulative length into saturation.
      idle_mode = 2;
      write_weight(16'hFFFF);
      send_cmd(plain_cmd(OP_CLEAR));
      for (int i = 0; i < 170; i++) begin
         if (i % 2 == 0)
            send_cmd(pose_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, HEADING_MAX));
         else
            send_cmd(pose_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
      end
      send_cmd(query_cmd(LEN_MAX));
      send_cmd(query_cmd(LEN_MAX - 40'd1));
      send_cmd(plain_cmd(OP_CLEAR));
      write_weight(WEIGHT_RESET);
      random_items(100);

      drain_results();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("path_arc_length_index_unit_tb passed");
      end else begin
         $display("path_arc_length_index_unit_tb failed");
      end
      $finish;
   end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pali_pkg.sv
hw/rtl/pali_cmd_queue.sv
hw/rtl/pali_engine.sv
hw/rtl/pali_front.sv
hw/rtl/path_arc_length_index_unit.sv
tb/sv/path_arc_length_index_unit_tb.sv
